/* sv/credit_fragmenter_reassembler_core_defines.svh */
// Assertion macros used by the port-level checker of the fragmenter/reassembler.
`ifndef CREDIT_FRAGMENTER_REASSEMBLER_CORE_DEFINES_SVH
`define CREDIT_FRAGMENTER_REASSEMBLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfr assertion failed");

`endif

/* sv/cfr_pkg.sv */
// Types and constants of the credit-based fragmenter/reassembler.
package cfr_pkg;

    localparam int FRAGMENT_BYTES_DEF = 56;
    localparam int FILL_W             = 6;
    localparam int OUTQ_DEPTH         = 4;
    localparam int OUTQ_PTR_W         = 2;
    localparam int OUTQ_CNT_W         = 3;

    localparam logic [2:0] OP_TX_BEGIN = 3'd0;
    localparam logic [2:0] OP_TX_BYTE  = 3'd1;
    localparam logic [2:0] OP_RX_HDR   = 3'd2;
    localparam logic [2:0] OP_RX_BYTE  = 3'd3;
    localparam logic [2:0] OP_SHUTDOWN = 3'd4;

    localparam logic [1:0] KIND_TX_FLAGS = 2'd0;
    localparam logic [1:0] KIND_TX_BYTE  = 2'd1;
    localparam logic [1:0] KIND_RX_BYTE  = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOTCONN = 3'd1;
    localparam logic [2:0] ST_STALL   = 3'd2;
    localparam logic [2:0] ST_NOFIRST = 3'd3;
    localparam logic [2:0] ST_LENERR  = 3'd4;

    localparam logic [7:0] FLAG_FIRST = 8'h01;
    localparam logic [7:0] FLAG_LAST  = 8'h02;
    localparam logic [7:0] FLAG_CLOSE = 8'h80;
    localparam logic [3:0] CREDIT_MASK = 4'hf;

    localparam logic [15:0] CREDITS_RESET = 16'd1;
    localparam logic [15:0] CREDITS_MAX   = 16'hffff;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data;
        logic [15:0] length;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  r0;
        t_out_item  r1;
    } t_push;

endpackage

/* sv/cfr_proc.sv */
// Connection state and per-transfer result generation.
module cfr_proc #(
    parameter int FRAGMENT_BYTES = cfr_pkg::FRAGMENT_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_accept,
    input  cfr_pkg::t_in_item i_item,
    output cfr_pkg::t_push   o_push
);

    localparam logic [cfr_pkg::FILL_W-1:0] FRAG_FILL = cfr_pkg::FILL_W'(FRAGMENT_BYTES);
    localparam logic [15:0]                FRAG_LEN  = 16'(FRAGMENT_BYTES);

    logic [15:0]               r_credits, n_credits;
    logic                      r_remote_closed, n_remote_closed;
    logic [15:0]               r_tx_remaining, n_tx_remaining;
    logic [cfr_pkg::FILL_W-1:0] r_tx_fill, n_tx_fill;
    logic                      r_tx_first_pending, n_tx_first_pending;
    logic [cfr_pkg::FILL_W-1:0] r_rx_remaining, n_rx_remaining;
    logic                      r_rx_is_last, n_rx_is_last;
    logic                      r_rx_in_message, n_rx_in_message;
    logic                      r_rx_dropping, n_rx_dropping;

    cfr_pkg::t_push            push;
    logic [16:0]               credit_sum;
    logic [7:0]                tx_flags;
    logic                      ends;

    always_comb begin
        n_credits          = r_credits;
        n_remote_closed    = r_remote_closed;
        n_tx_remaining     = r_tx_remaining;
        n_tx_fill          = r_tx_fill;
        n_tx_first_pending = r_tx_first_pending;
        n_rx_remaining     = r_rx_remaining;
        n_rx_is_last       = r_rx_is_last;
        n_rx_in_message    = r_rx_in_message;
        n_rx_dropping      = r_rx_dropping;
        credit_sum         = {1'b0, r_credits} + 17'(i_item.data[5:2] & cfr_pkg::CREDIT_MASK);
        tx_flags           = 8'h00;
        ends               = 1'b0;
        push.count         = 2'd1;
        push.r0            = '{kind: cfr_pkg::KIND_STATUS, out_byte: 8'h00, last: 1'b0,
                               status: cfr_pkg::ST_OK};
        push.r1            = push.r0;

        case (i_item.op)
            cfr_pkg::OP_TX_BEGIN: begin
                if (r_remote_closed) begin
                    push.r0.status = cfr_pkg::ST_NOTCONN;
                end else begin
                    n_tx_remaining     = i_item.length;
                    n_tx_fill          = '0;
                    n_tx_first_pending = 1'b1;
                end
            end
            cfr_pkg::OP_TX_BYTE: begin
                if (r_tx_remaining == 16'd0) begin
                    push.r0.status = cfr_pkg::ST_LENERR;
                end else if (r_tx_fill == '0 && r_remote_closed) begin
                    push.r0.status = cfr_pkg::ST_NOTCONN;
                end else if (r_tx_fill == '0 && r_credits == 16'd0) begin
                    push.r0.status = cfr_pkg::ST_STALL;
                end else begin
                    n_tx_remaining = r_tx_remaining - 16'd1;
                    n_tx_fill      = r_tx_fill + cfr_pkg::FILL_W'(1);
                    ends           = (n_tx_remaining == 16'd0) || (n_tx_fill >= FRAG_FILL);
                    if (ends) begin
                        n_tx_fill = '0;
                    end
                    push.r1 = '{kind: cfr_pkg::KIND_TX_BYTE, out_byte: i_item.data,
                                last: ends, status: cfr_pkg::ST_OK};
                    if (r_tx_fill == '0) begin
                        n_credits = r_credits - 16'd1;
                        if (r_tx_first_pending) begin
                            tx_flags = tx_flags | cfr_pkg::FLAG_FIRST;
                        end
                        if (r_tx_remaining <= FRAG_LEN) begin
                            tx_flags = tx_flags | cfr_pkg::FLAG_LAST;
                        end
                        n_tx_first_pending = 1'b0;
                        push.count = 2'd2;
                        push.r0    = '{kind: cfr_pkg::KIND_TX_FLAGS, out_byte: tx_flags,
                                       last: 1'b0, status: cfr_pkg::ST_OK};
                    end else begin
                        push.r0 = push.r1;
                    end
                end
            end
            cfr_pkg::OP_RX_HDR: begin
                n_rx_remaining = '0;
                if ((i_item.data & cfr_pkg::FLAG_CLOSE) != 8'h00) begin
                    n_remote_closed = 1'b1;
                end else begin
                    n_credits = credit_sum[16] ? cfr_pkg::CREDITS_MAX : credit_sum[15:0];
                    if (i_item.length > FRAG_LEN) begin
                        push.r0.status = cfr_pkg::ST_LENERR;
                    end else if (i_item.length != 16'd0) begin
                        n_rx_remaining = i_item.length[cfr_pkg::FILL_W-1:0];
                        n_rx_is_last   = (i_item.data & cfr_pkg::FLAG_LAST) != 8'h00;
                        if (!r_rx_in_message) begin
                            if ((i_item.data & cfr_pkg::FLAG_FIRST) != 8'h00) begin
                                n_rx_in_message = 1'b1;
                                n_rx_dropping   = 1'b0;
                            end else begin
                                n_rx_dropping = 1'b1;
                            end
                        end
                        if (n_rx_dropping) begin
                            push.r0.status = cfr_pkg::ST_NOFIRST;
                        end
                    end
                end
            end
            cfr_pkg::OP_RX_BYTE: begin
                if (r_rx_remaining == '0) begin
                    push.r0.status = cfr_pkg::ST_LENERR;
                end else begin
                    n_rx_remaining = r_rx_remaining - cfr_pkg::FILL_W'(1);
                    ends           = (n_rx_remaining == '0) && r_rx_is_last;
                    if (r_rx_dropping) begin
                        if (ends) begin
                            n_rx_dropping = 1'b0;
                        end
                        push.r0.status = cfr_pkg::ST_NOFIRST;
                    end else begin
                        if (ends) begin
                            n_rx_in_message = 1'b0;
                        end
                        push.r0 = '{kind: cfr_pkg::KIND_RX_BYTE, out_byte: i_item.data,
                                    last: ends, status: cfr_pkg::ST_OK};
                    end
                end
            end
            cfr_pkg::OP_SHUTDOWN: begin
                push.r0 = '{kind: cfr_pkg::KIND_TX_FLAGS, out_byte: cfr_pkg::FLAG_CLOSE,
                            last: 1'b1, status: cfr_pkg::ST_OK};
            end
            default: begin
                push.count = 2'd0;
            end
        endcase

        if (!i_accept) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits          <= cfr_pkg::CREDITS_RESET;
            r_remote_closed    <= 1'b0;
            r_tx_remaining     <= '0;
            r_tx_fill          <= '0;
            r_tx_first_pending <= 1'b0;
            r_rx_remaining     <= '0;
            r_rx_is_last       <= 1'b0;
            r_rx_in_message    <= 1'b0;
            r_rx_dropping      <= 1'b0;
        end else if (i_cfg_we) begin
            r_credits <= i_cfg_data;
        end else if (i_accept) begin
            r_credits          <= n_credits;
            r_remote_closed    <= n_remote_closed;
            r_tx_remaining     <= n_tx_remaining;
            r_tx_fill          <= n_tx_fill;
            r_tx_first_pending <= n_tx_first_pending;
            r_rx_remaining     <= n_rx_remaining;
            r_rx_is_last       <= n_rx_is_last;
            r_rx_in_message    <= n_rx_in_message;
            r_rx_dropping      <= n_rx_dropping;
        end
    end

endmodule

/* sv/cfr_outq.sv */
// Result queue: takes up to two results per cycle, delivers one per transfer.
module cfr_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfr_pkg::t_push     i_push,
    input  logic               i_stall,
    output logic               o_valid,
    output cfr_pkg::t_out_item o_item,
    output logic               o_almost_full
);

    cfr_pkg::t_out_item                r_mem [cfr_pkg::OUTQ_DEPTH];
    logic [cfr_pkg::OUTQ_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [cfr_pkg::OUTQ_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [cfr_pkg::OUTQ_CNT_W-1:0]    r_count, n_count;
    logic                              pop;
    logic [cfr_pkg::OUTQ_PTR_W-1:0]    wr_ptr_next;

    assign o_valid       = r_count != '0;
    assign o_item        = r_mem[r_rd_ptr];
    assign o_almost_full = r_count > cfr_pkg::OUTQ_CNT_W'(cfr_pkg::OUTQ_DEPTH - 2);
    assign pop           = o_valid && !i_stall;
    assign wr_ptr_next   = r_wr_ptr + cfr_pkg::OUTQ_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + cfr_pkg::OUTQ_PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + cfr_pkg::OUTQ_PTR_W'(pop);
        n_count  = r_count + cfr_pkg::OUTQ_CNT_W'(i_push.count)
                   - cfr_pkg::OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* sv/credit_fragmenter_reassembler_core.sv */
// Top level of the credit-based fragmenter and reassembler.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one operation
// per transfer: tx begin, tx byte, rx header, rx byte or shutdown. Output
// channel (o_out_valid / i_out_stall / o_out_item) carries result items:
// tx flags bytes, tx payload bytes, rx message bytes and status words.
// Each operation gives one result, except the first byte of a tx fragment,
// which gives the flags byte and then the payload byte; unused op codes give
// none. Results are registered in the queue before they reach the output.
// A four-entry result queue parts the two sides: the block takes an input
// every cycle while two entries are free. The output moves one beat per
// cycle, so with the receiver taking every beat a run of tx bytes meets
// o_in_stall after each fragment start after the first; other operations
// flow at one per cycle.
// When the receiver stalls, the queue holds its head and o_in_stall rises
// once fewer than two entries are free.
// The credit counter is loaded directly through i_cfg_we / i_cfg_data.
// Synchronous reset empties the queue, clears the connection state and
// sets credits to one.
module credit_fragmenter_reassembler_core #(
    parameter int FRAGMENT_BYTES = cfr_pkg::FRAGMENT_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cfr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cfr_pkg::t_out_item o_out_item
);

    cfr_pkg::t_push push;
    logic           accept;
    logic           almost_full;

    assign o_in_stall = almost_full;
    assign accept     = i_in_valid && !almost_full;

    cfr_proc #(
        .FRAGMENT_BYTES(FRAGMENT_BYTES)
    ) u_proc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_push     (push)
    );

    cfr_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_item        (o_out_item),
        .o_almost_full (almost_full)
    );

endmodule

/* sv/cfr_checker.sv */
// Port-level checks of the fragmenter/reassembler, bound to the top level.
`include "credit_fragmenter_reassembler_core_defines.svh"

module cfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input cfr_pkg::t_out_item i_out_item
);

    logic held;
    logic is_flags;
    logic is_status;
    logic is_data;
    logic flags_ok;
    logic status_clean;
    logic data_ok;

    assign held         = i_out_valid && i_out_stall;
    assign is_flags     = i_out_valid && i_out_item.kind == cfr_pkg::KIND_TX_FLAGS;
    assign is_status    = i_out_valid && i_out_item.kind == cfr_pkg::KIND_STATUS;
    assign is_data      = i_out_valid && i_out_item.kind != cfr_pkg::KIND_STATUS;
    assign flags_ok     = (i_out_item.last == (i_out_item.out_byte == cfr_pkg::FLAG_CLOSE))
                          && i_out_item.status == cfr_pkg::ST_OK;
    assign status_clean = i_out_item.out_byte == 8'h00 && !i_out_item.last;
    assign data_ok      = i_out_item.status == cfr_pkg::ST_OK;

    `CFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, held, i_out_valid && $stable(i_out_item))
    `CFR_ASSERT_NOW(a_flags_last, i_clk, i_rst_n, is_flags, flags_ok)
    `CFR_ASSERT_NOW(a_status_clean, i_clk, i_rst_n, is_status, status_clean)
    `CFR_ASSERT_NOW(a_data_ok, i_clk, i_rst_n, is_data, data_ok)

endmodule

bind credit_fragmenter_reassembler_core cfr_checker u_cfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

/* verif/cfr_link_checker.sv */
// Checker for the credit fragmenter/reassembler: predicts result beats and compares them.
module cfr_link_checker #(
    parameter int FRAG_BYTES = cfr_pkg::FRAGMENT_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cfr_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cfr_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_owed_count
);

    localparam int SHOWN_MAX = 10;

    logic [15:0]                credits;
    logic                       remote_closed;
    logic [15:0]                tx_left;
    logic [cfr_pkg::FILL_W-1:0] tx_fill;
    logic                       tx_first;
    logic [cfr_pkg::FILL_W-1:0] rx_left;
    logic                       rx_last_frame;
    logic                       rx_in_msg;
    logic                       rx_drop;

    cfr_pkg::t_out_item owed_beats[$];
    int                 fail_total = 0;

    function automatic cfr_pkg::t_out_item beat(input logic [1:0] kind, input logic [7:0] val,
                                                input logic fin, input logic [2:0] st);
        cfr_pkg::t_out_item b;
        b.kind     = kind;
        b.out_byte = val;
        b.last     = fin;
        b.status   = st;
        return b;
    endfunction

    function automatic int conn_step(input cfr_pkg::t_in_item it,
                                     output cfr_pkg::t_out_item r0,
                                     output cfr_pkg::t_out_item r1);
        logic [7:0]         flags;
        logic [16:0]        sum;
        logic               ends;
        cfr_pkg::t_out_item b;
        int                 n;
        n  = 0;
        r0 = '0;
        r1 = '0;
        case (it.op)
            cfr_pkg::OP_TX_BEGIN: begin
                if (remote_closed) begin
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_NOTCONN);
                    return 1;
                end
                tx_left  = it.length;
                tx_fill  = '0;
                tx_first = 1'b1;
                r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_OK);
                return 1;
            end
            cfr_pkg::OP_TX_BYTE: begin
                if (tx_left == 16'd0) begin
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_LENERR);
                    return 1;
                end
                if (tx_fill == '0) begin
                    if (remote_closed) begin
                        r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_NOTCONN);
                        return 1;
                    end
                    if (credits == 16'd0) begin
                        r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_STALL);
                        return 1;
                    end
                    credits = credits - 16'd1;
                    flags = '0;
                    if (tx_first) flags = flags | cfr_pkg::FLAG_FIRST;
                    if (int'(tx_left) <= FRAG_BYTES) flags = flags | cfr_pkg::FLAG_LAST;
                    tx_first = 1'b0;
                    r0 = beat(cfr_pkg::KIND_TX_FLAGS, flags, 1'b0, cfr_pkg::ST_OK);
                    n = 1;
                end
                tx_left = tx_left - 16'd1;
                tx_fill = tx_fill + cfr_pkg::FILL_W'(1);
                ends = (tx_left == 16'd0) || (int'(tx_fill) >= FRAG_BYTES);
                if (ends) tx_fill = '0;
                b = beat(cfr_pkg::KIND_TX_BYTE, it.data, ends, cfr_pkg::ST_OK);
                if (n == 0) r0 = b;
                else r1 = b;
                return n + 1;
            end
            cfr_pkg::OP_RX_HDR: begin
                if ((it.data & cfr_pkg::FLAG_CLOSE) != 8'h00) begin
                    remote_closed = 1'b1;
                    rx_left = '0;
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_OK);
                    return 1;
                end
                sum = {1'b0, credits} + 17'(it.data[5:2] & cfr_pkg::CREDIT_MASK);
                credits = sum[16] ? cfr_pkg::CREDITS_MAX : sum[15:0];
                rx_left = '0;
                if (int'(it.length) > FRAG_BYTES) begin
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_LENERR);
                    return 1;
                end
                if (it.length == 16'd0) begin
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_OK);
                    return 1;
                end
                rx_left = it.length[cfr_pkg::FILL_W-1:0];
                rx_last_frame = (it.data & cfr_pkg::FLAG_LAST) != 8'h00;
                if (!rx_in_msg) begin
                    if ((it.data & cfr_pkg::FLAG_FIRST) != 8'h00) begin
                        rx_in_msg = 1'b1;
                        rx_drop   = 1'b0;
                    end else begin
                        rx_drop = 1'b1;
                    end
                end
                r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0,
                          rx_drop ? cfr_pkg::ST_NOFIRST : cfr_pkg::ST_OK);
                return 1;
            end
            cfr_pkg::OP_RX_BYTE: begin
                if (rx_left == '0) begin
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_LENERR);
                    return 1;
                end
                rx_left = rx_left - cfr_pkg::FILL_W'(1);
                ends = (rx_left == '0) && rx_last_frame;
                if (rx_drop) begin
                    if (ends) rx_drop = 1'b0;
                    r0 = beat(cfr_pkg::KIND_STATUS, 8'h00, 1'b0, cfr_pkg::ST_NOFIRST);
                    return 1;
                end
                if (ends) rx_in_msg = 1'b0;
                r0 = beat(cfr_pkg::KIND_RX_BYTE, it.data, ends, cfr_pkg::ST_OK);
                return 1;
            end
            cfr_pkg::OP_SHUTDOWN: begin
                r0 = beat(cfr_pkg::KIND_TX_FLAGS, cfr_pkg::FLAG_CLOSE, 1'b1, cfr_pkg::ST_OK);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cfr_pkg::t_out_item want;
        cfr_pkg::t_out_item r0;
        cfr_pkg::t_out_item r1;
        int                 n;
        if (!i_rst_n) begin
            credits       = cfr_pkg::CREDITS_RESET;
            remote_closed = 1'b0;
            tx_left       = '0;
            tx_fill       = '0;
            tx_first      = 1'b0;
            rx_left       = '0;
            rx_last_frame = 1'b0;
            rx_in_msg     = 1'b0;
            rx_drop       = 1'b0;
            owed_beats.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_beats.size() == 0) begin
                    fail_total++;
                    if (fail_total <= SHOWN_MAX)
                        $display("%0t: unexpected beat kind %0d byte %02h last %0d status %0d",
                                 $realtime, i_out_item.kind, i_out_item.out_byte,
                                 i_out_item.last, i_out_item.status);
                end else begin
                    want = owed_beats.pop_front();
                    if (want.kind !== i_out_item.kind || want.out_byte !== i_out_item.out_byte ||
                        want.last !== i_out_item.last || want.status !== i_out_item.status) begin
                        fail_total++;
                        if (fail_total <= SHOWN_MAX)
                            $display({"%0t: mismatch expected kind %0d byte %02h last %0d ",
                                      "status %0d, got kind %0d byte %02h last %0d status %0d"},
                                     $realtime, want.kind, want.out_byte, want.last,
                                     want.status, i_out_item.kind, i_out_item.out_byte,
                                     i_out_item.last, i_out_item.status);
                    end
                end
            end
            if (i_cfg_we) begin
                credits = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                n = conn_step(i_in_item, r0, r1);
                if (n > 0) owed_beats.push_back(r0);
                if (n > 1) owed_beats.push_back(r1);
            end
        end
        o_owed_count <= owed_beats.size();
        o_fail_count <= fail_total;
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for the credit fragmenter/reassembler: stimulus, flow control and verdict.
module tb_top;

    localparam int FRAG        = cfr_pkg::FRAGMENT_BYTES_DEF;
    localparam int OP_CODES    = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 4;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [15:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    cfr_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    cfr_pkg::t_out_item out_item;
    int                 fail_count;
    int                 owed_count;
    int                 cycles     = 0;
    int                 items_sent = 0;
    int                 stall_left = 0;
    bit                 tx_quiet   = 1'b0;
    bit                 rx_quiet   = 1'b0;
    bit                 hold_req   = 1'b0;

    credit_fragmenter_reassembler_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    cfr_link_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_owed_count(owed_count)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold off for a long stretch on request, otherwise stall in random bursts unless rx_quiet is set
    always @(posedge clk) begin
        int r;
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && !rx_quiet) begin
            r = $urandom_range(0, 99);
            if (r < 60) stall_left = 0;
            else if (r < 95) stall_left = $urandom_range(1, 3);
            else stall_left = $urandom_range(10, 40);
        end
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    function automatic cfr_pkg::t_in_item mk_op(input logic [2:0] code, input logic [7:0] dat,
                                                input logic [15:0] len);
        cfr_pkg::t_in_item it;
        it.op     = code;
        it.data   = dat;
        it.length = len;
        return it;
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rnd_len();
        return 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, FRAG + 4));
    endfunction

    task automatic send(input cfr_pkg::t_in_item it);
        int r;
        int gap;
        bit took;
        gap = 0;
        if (!tx_quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(8, 30);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
        if (it.op <= cfr_pkg::OP_SHUTDOWN) items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (owed_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_credits(input logic [15:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic tx_message(input int len);
        int i;
        send(mk_op(cfr_pkg::OP_TX_BEGIN, rnd_byte(), 16'(len)));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 3)
                send(mk_op(cfr_pkg::OP_SHUTDOWN, rnd_byte(), 16'($urandom_range(0, 65535))));
            send(mk_op(cfr_pkg::OP_TX_BYTE, rnd_byte(), 16'($urandom_range(0, 65535))));
        end
    endtask

    task automatic rx_message(input int frames, input bit opened, input bit ragged);
        int f;
        int i;
        int r;
        int len;
        int cnt;
        logic [7:0] hdr;
        for (f = 0; f < frames; f++) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 12);
            else if (r < 95) len = $urandom_range(13, FRAG - 1);
            else len = FRAG;
            hdr      = '0;
            hdr[6]   = 1'($urandom_range(0, 1));
            hdr[5:2] = 4'($urandom_range(0, int'(cfr_pkg::CREDIT_MASK)));
            if (f == frames - 1) hdr = hdr | cfr_pkg::FLAG_LAST;
            if (f == 0 && opened) hdr = hdr | cfr_pkg::FLAG_FIRST;
            if (ragged && $urandom_range(0, 3) == 0)
                len = $urandom_range(0, 1) ? 0 : $urandom_range(FRAG + 1, 65535);
            send(mk_op(cfr_pkg::OP_RX_HDR, hdr, 16'(len)));
            if (!ragged) cnt = len;
            else if (len > FRAG) cnt = $urandom_range(0, 3);
            else cnt = $urandom_range(0, len + 2);
            for (i = 0; i < cnt; i++)
                send(mk_op(cfr_pkg::OP_RX_BYTE, rnd_byte(), 16'($urandom_range(0, 65535))));
        end
    endtask

    task automatic random_traffic(input int quota);
        int stop;
        int r;
        int i;
        logic [2:0] code;
        logic [7:0] dat;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                r = $urandom_range(0, 99);
                if (r < 75) tx_message($urandom_range(1, 20));
                else tx_message($urandom_range(21, 130));
            end else if (r < 70) begin
                rx_message($urandom_range(1, 3), 1'b1, 1'b0);
            end else if (r < 78) begin
                rx_message($urandom_range(1, 3), 1'b0, 1'b0);
            end else if (r < 85) begin
                rx_message($urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b1);
            end else if (r < 90) begin
                send(mk_op(cfr_pkg::OP_TX_BEGIN, rnd_byte(), 16'($urandom_range(0, 65535))));
                for (i = $urandom_range(0, 5); i > 0; i--)
                    send(mk_op(cfr_pkg::OP_TX_BYTE, rnd_byte(), 16'($urandom_range(0, 65535))));
            end else begin
                code = 3'($urandom_range(0, OP_CODES - 1));
                dat  = rnd_byte();
                if (code == cfr_pkg::OP_RX_HDR) dat = dat & ~cfr_pkg::FLAG_CLOSE;
                send(mk_op(code, dat, rnd_len()));
            end
        end
    endtask

    initial begin
        int i;
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'hff, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_BYTE, 8'h00, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'h00, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'h5a, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'hff, 16'd2));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'h00, 16'hffff));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'hff, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'h00, 16'd1));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'h81, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_HDR, 8'h3c, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'h7e, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_HDR, cfr_pkg::FLAG_FIRST | 8'h40, 16'(FRAG + 1)));
        send(mk_op(cfr_pkg::OP_RX_HDR, cfr_pkg::FLAG_LAST, 16'd2));
        send(mk_op(cfr_pkg::OP_RX_BYTE, 8'h11, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_BYTE, 8'h22, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_HDR, cfr_pkg::FLAG_FIRST, 16'd3));
        send(mk_op(cfr_pkg::OP_RX_BYTE, 8'h33, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_HDR, cfr_pkg::FLAG_FIRST | cfr_pkg::FLAG_LAST, 16'd1));
        send(mk_op(cfr_pkg::OP_RX_BYTE, 8'hcc, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_HDR, 8'h7f, 16'hffff));
        for (k = int'(cfr_pkg::OP_SHUTDOWN) + 1; k < OP_CODES; k++)
            send(mk_op(3'(k), 8'hff, 16'hffff));
        send(mk_op(cfr_pkg::OP_SHUTDOWN, 8'h00, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'h00, 16'hffff));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'ha5, 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'h00, 16'd1));
        send(mk_op(cfr_pkg::OP_TX_BYTE, 8'h3c, 16'd0));

        set_credits(16'd0);
        random_traffic(300);

        set_credits(cfr_pkg::CREDITS_MAX);
        random_traffic(150);
        hold_req = 1'b1;
        tx_message(60);
        drain();
        random_traffic(150);

        set_credits(16'($urandom_range(2, 400)));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        random_traffic(300);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        set_credits(cfr_pkg::CREDITS_RESET);
        random_traffic(300);

        // close the remote side with a fragment half sent, then finish it
        set_credits(16'd20);
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'h00, 16'd60));
        for (i = 0; i < 3; i++) send(mk_op(cfr_pkg::OP_TX_BYTE, rnd_byte(), 16'd0));
        send(mk_op(cfr_pkg::OP_SHUTDOWN, 8'h00, 16'd0));
        send(mk_op(cfr_pkg::OP_RX_HDR, cfr_pkg::FLAG_CLOSE | cfr_pkg::FLAG_FIRST, 16'd5));
        send(mk_op(cfr_pkg::OP_RX_BYTE, 8'h44, 16'd0));
        for (i = 0; i < 57; i++) send(mk_op(cfr_pkg::OP_TX_BYTE, rnd_byte(), 16'd0));
        send(mk_op(cfr_pkg::OP_TX_BEGIN, 8'h00, 16'd4));
        send(mk_op(cfr_pkg::OP_RX_HDR, 8'hff, 16'hffff));
        for (i = 0; i < 40; i++)
            send(mk_op(3'($urandom_range(0, OP_CODES - 1)), rnd_byte(), rnd_len()));

        drain();
        if (fail_count == 0 && owed_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/cfr_pkg.sv
sv/cfr_proc.sv
sv/cfr_outq.sv
sv/credit_fragmenter_reassembler_core.sv
sv/cfr_checker.sv
verif/cfr_link_checker.sv
verif/tb_top.sv
